[hw/rtl/rmd_pkg.sv]
`timescale 1ns / 1ps

package rmd_pkg;

    localparam int unsigned WIDTH  = 32;
    localparam int unsigned PROD_W = 2 * WIDTH;
    localparam int unsigned MAG_W  = PROD_W - 1;
    localparam int unsigned STEPS  = WIDTH;

    typedef logic [WIDTH-1:0] t_word;

    typedef struct packed {
        logic  neg;
        logic  err;
        t_word dmag;
        t_word rem;
        t_word low;
    } t_div_req;

endpackage

[hw/rtl/rmd_ifs.sv]
`timescale 1ns / 1ps

interface rmd_in_if;
    logic                             valid;
    logic                             ready;
    logic signed [rmd_pkg::WIDTH-1:0] value;
    logic signed [rmd_pkg::WIDTH-1:0] multiplier;
    logic signed [rmd_pkg::WIDTH-1:0] divisor;

    modport source (output valid, output value, output multiplier, output divisor,
                    input ready);
    modport sink (input valid, input value, input multiplier, input divisor,
                  output ready);
endinterface

interface rmd_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [rmd_pkg::WIDTH-1:0] quotient;
    logic                             error_flag;

    modport source (output valid, output quotient, output error_flag, input ready);
    modport sink (input valid, input quotient, input error_flag, output ready);
endinterface

[hw/rtl/rmd_div.sv]
`timescale 1ns / 1ps

module rmd_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    output logic              o_rdy,
    input  rmd_pkg::t_div_req i_req,
    rmd_out_if.source         o_out
);

    localparam int unsigned W     = rmd_pkg::WIDTH;
    localparam int unsigned STEPS = rmd_pkg::STEPS;

    function automatic rmd_pkg::t_div_req div_step(input rmd_pkg::t_div_req cur);
        logic [W:0]        trial;
        logic              ge;
        rmd_pkg::t_div_req nxt;
        trial    = {cur.rem, cur.low[W-1]};
        ge       = trial >= {1'b0, cur.dmag};
        nxt      = cur;
        nxt.rem  = ge ? W'(trial - {1'b0, cur.dmag}) : trial[W-1:0];
        nxt.low  = {cur.low[W-2:0], ge};
        return nxt;
    endfunction

    logic              r_vld [0:STEPS-1];
    rmd_pkg::t_div_req r_st  [0:STEPS-1];
    logic              w_en  [0:STEPS];
    logic              w_src_vld [0:STEPS-1];
    rmd_pkg::t_div_req w_src [0:STEPS-1];

    logic              r_ovld;
    rmd_pkg::t_word    r_oq;
    logic              r_oerr;

    rmd_pkg::t_div_req w_last;
    rmd_pkg::t_word    w_qmag;
    logic              w_ovf;
    logic              n_err;
    rmd_pkg::t_word    n_q;

    assign w_src_vld[0] = i_vld;
    assign w_src[0]     = i_req;
    assign w_en[STEPS]  = !r_ovld || o_out.ready;
    assign o_rdy        = w_en[0];

    for (genvar s = 0; s < STEPS; s++) begin : g_step
        if (s > 0) begin : g_link
            assign w_src_vld[s] = r_vld[s-1];
            assign w_src[s]     = r_st[s-1];
        end

        assign w_en[s] = !r_vld[s] || w_en[s+1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (w_en[s]) begin
                r_vld[s] <= w_src_vld[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en[s]) begin
                r_st[s] <= div_step(w_src[s]);
            end
        end
    end

    // quotient magnitude sits in the low field after the last step
    assign w_last = r_st[STEPS-1];
    assign w_qmag = w_last.low;
    assign w_ovf  = w_last.neg ? (w_qmag[W-1] && (w_qmag[W-2:0] != '0)) : w_qmag[W-1];
    assign n_err  = w_last.err || w_ovf;
    assign n_q    = n_err ? '1 : (w_last.neg ? W'(-w_qmag) : w_qmag);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (w_en[STEPS]) begin
            r_ovld <= r_vld[STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[STEPS]) begin
            r_oq   <= n_q;
            r_oerr <= n_err;
        end
    end

    assign o_out.valid      = r_ovld;
    assign o_out.quotient   = r_oq;
    assign o_out.error_flag = r_oerr;

    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[STEPS-1] && !r_st[STEPS-1].err |-> r_st[STEPS-1].rem < r_st[STEPS-1].dmag)
        else $error("remainder not below divisor after last step");

    a_err_all_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovld && r_oerr |-> r_oq == '1)
        else $error("error item without all-ones quotient");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_rdy |-> r_ovld && !o_out.ready && r_vld[0] && r_vld[STEPS-1])
        else $error("divider stalls input without a full pipeline");

endmodule

[hw/rtl/rounded_multiply_divide.sv]
`timescale 1ns / 1ps

// Rounded multiply-divide, 32-bit signed.
// Input channel i_in carries value, multiplier and divisor; output channel
// o_out carries quotient and error_flag, one result item for each input item,
// in order. Both use valid/ready; an item moves when both are high.
// The result is value*multiplier/divisor rounded half away from zero. A zero
// divisor or a quotient outside the signed 32-bit range gives -1 with
// error_flag set.
// Each item passes from acceptance to o_out.valid through 37 register
// stages: one multiply stage, magnitude, rounding add and range precheck
// stages, 32 restoring division stages at one quotient bit each, and the
// output register.
// Throughput is one item per cycle while o_out.ready is high; every stage
// has its own valid bit and advances when it is empty or its successor
// advances, so empty stages are filled while o_out is stalled; i_in.ready
// drops only when all 37 stages hold items and o_out.ready is low. Nothing
// is lost or repeated. Reset (i_rst_n low at a clock edge) empties the
// pipeline; no state is kept between items.

module rounded_multiply_divide (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rmd_in_if.sink    i_in,
    rmd_out_if.source o_out
);

    localparam int unsigned W     = rmd_pkg::WIDTH;
    localparam int unsigned PW    = rmd_pkg::PROD_W;
    localparam int unsigned MW    = rmd_pkg::MAG_W;

    logic                 w_en1, w_en2, w_en3, w_en4;
    logic                 w_div_rdy;

    logic                 r1_vld;
    logic signed [PW-1:0] r1_prod;
    logic signed [W-1:0]  r1_div;
    logic signed [PW-1:0] n_prod;

    logic                 r2_vld;
    logic [MW-1:0]        r2_mag;
    rmd_pkg::t_word       r2_dmag;
    logic                 r2_neg;
    logic                 r2_zero;
    logic [PW-1:0]        n_pabs;
    rmd_pkg::t_word       n_dabs;

    logic                 r3_vld;
    logic [MW-1:0]        r3_num;
    rmd_pkg::t_word       r3_dmag;
    logic                 r3_neg;
    logic                 r3_zero;

    logic                 r4_vld;
    rmd_pkg::t_div_req    r4_req;
    rmd_pkg::t_word       n_hi;
    logic                 n_over;

    assign w_en4      = !r4_vld || w_div_rdy;
    assign w_en3      = !r3_vld || w_en4;
    assign w_en2      = !r2_vld || w_en3;
    assign w_en1      = !r1_vld || w_en2;
    assign i_in.ready = w_en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else begin
            if (w_en1) begin
                r1_vld <= i_in.valid;
            end
            if (w_en2) begin
                r2_vld <= r1_vld;
            end
            if (w_en3) begin
                r3_vld <= r2_vld;
            end
            if (w_en4) begin
                r4_vld <= r3_vld;
            end
        end
    end

    // exact product
    assign n_prod = i_in.value * i_in.multiplier;

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r1_prod <= n_prod;
            r1_div  <= i_in.divisor;
        end
    end

    // magnitudes and result sign
    assign n_pabs = r1_prod[PW-1] ? PW'(-r1_prod) : PW'(r1_prod);
    assign n_dabs = r1_div[W-1] ? W'(-r1_div) : W'(r1_div);

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r2_mag  <= n_pabs[MW-1:0];
            r2_dmag <= n_dabs;
            r2_neg  <= r1_prod[PW-1] ^ r1_div[W-1];
            r2_zero <= (r1_div == '0);
        end
    end

    // add half the divisor magnitude
    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r3_num  <= r2_mag + MW'(r2_dmag[W-1:1]);
            r3_dmag <= r2_dmag;
            r3_neg  <= r2_neg;
            r3_zero <= r2_zero;
        end
    end

    // quotient of 2^32 or more when the upper half reaches the divisor
    assign n_hi   = W'(r3_num[MW-1:W]);
    assign n_over = n_hi >= r3_dmag;

    always_ff @(posedge i_clk) begin
        if (w_en4) begin
            r4_req.neg  <= r3_neg;
            r4_req.err  <= r3_zero || n_over;
            r4_req.dmag <= r3_dmag;
            r4_req.rem  <= n_hi;
            r4_req.low  <= r3_num[W-1:0];
        end
    end

    rmd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r4_vld),
        .o_rdy   (w_div_rdy),
        .i_req   (r4_req),
        .o_out   (o_out)
    );

    a_mag_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r2_vld |-> !r2_mag[MW-1] || (r2_mag[MW-2:0] == '0))
        else $error("product magnitude above 2^62");

    a_precheck_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r4_vld && !r4_req.err |-> r4_req.rem < r4_req.dmag)
        else $error("division started with remainder not below divisor");

    a_input_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> r1_vld && r2_vld && r3_vld && r4_vld && !w_div_rdy)
        else $error("input stalled with an empty front stage");

endmodule

[tb/rmd_checker.sv]
`timescale 1ns / 1ps

module rmd_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             i_in_ready,
    input  logic signed [rmd_pkg::WIDTH-1:0] i_value,
    input  logic signed [rmd_pkg::WIDTH-1:0] i_multiplier,
    input  logic signed [rmd_pkg::WIDTH-1:0] i_divisor,
    input  logic                             i_out_valid,
    input  logic                             i_out_ready,
    input  logic signed [rmd_pkg::WIDTH-1:0] i_quotient,
    input  logic                             i_error_flag,
    output int                               o_fail_count,
    output int                               o_pending
);

    typedef struct {
        rmd_pkg::t_word quotient;
        logic           error_flag;
    } t_result;

    localparam longint         QUOT_MAX      = 64'sd2147483647;
    localparam longint         QUOT_MIN      = -64'sd2147483648;
    localparam rmd_pkg::t_word QUOT_ON_ERROR = '1;
    localparam int             REPORT_LIMIT  = 10;

    t_result pending_results[$];
    int      fail_count = 0;
    int      reported   = 0;

    function automatic t_result rounded_quotient(longint a, longint b, longint d);
        t_result r;
        longint  product;
        longint  half;
        longint  q;
        r.quotient   = QUOT_ON_ERROR;
        r.error_flag = 1'b1;
        if (d == 0) begin
            return r;
        end
        product = a * b;
        half    = d / 2;
        if ((product < 0) != (d < 0)) begin
            half = -half;
        end
        q = (product + half) / d;
        if (q > QUOT_MAX || q < QUOT_MIN) begin
            return r;
        end
        r.quotient   = rmd_pkg::t_word'(q);
        r.error_flag = 1'b0;
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_result want;
        if (i_rst_n && i_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                fail_count++;
                if (reported < REPORT_LIMIT) begin
                    reported++;
                    $display("unexpected item: quotient %0d error_flag %b",
                             i_quotient, i_error_flag);
                end
            end else begin
                want = pending_results.pop_front();
                if (i_quotient !== want.quotient || i_error_flag !== want.error_flag) begin
                    fail_count++;
                    if (reported < REPORT_LIMIT) begin
                        reported++;
                        $display("mismatch: expected quotient %0d error_flag %b, got %0d %b",
                                 $signed(want.quotient), want.error_flag,
                                 i_quotient, i_error_flag);
                    end
                end
            end
        end
        if (i_rst_n && i_in_valid && i_in_ready) begin
            pending_results.push_back(rounded_quotient(i_value, i_multiplier, i_divisor));
        end
        o_pending    <= pending_results.size();
        o_fail_count <= fail_count;
    end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    localparam int             RESET_CYCLES  = 9;
    localparam int             DRAIN_CYCLES  = 50;
    localparam int             CYCLE_LIMIT   = 400000;
    localparam int             PHASE_ITEMS   = 325;
    localparam int             NUM_PHASES    = 4;
    localparam rmd_pkg::t_word WORD_MAX      = 32'h7FFF_FFFF;
    localparam rmd_pkg::t_word WORD_MIN      = 32'h8000_0000;

    logic clk;
    logic rst_n;
    int   idle_pct  = 0;
    int   stall_pct = 0;
    int   cycle_count = 0;
    int   fail_count;
    int   pending;

    rmd_in_if  in_ch ();
    rmd_out_if out_ch ();

    rounded_multiply_divide dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    rmd_checker checker_inst (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_ch.valid),
        .i_in_ready   (in_ch.ready),
        .i_value      (in_ch.value),
        .i_multiplier (in_ch.multiplier),
        .i_divisor    (in_ch.divisor),
        .i_out_valid  (out_ch.valid),
        .i_out_ready  (out_ch.ready),
        .i_quotient   (out_ch.quotient),
        .i_error_flag (out_ch.error_flag),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge clk) begin
        out_ch.ready <= (int'($urandom_range(99)) >= stall_pct);
    end

    function automatic int rand_between(int lo, int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    function automatic int rand_nonzero(int lo, int hi);
        int d;
        d = rand_between(lo, hi);
        return (d == 0) ? 1 : d;
    endfunction

    task automatic send_operands(input rmd_pkg::t_word value,
                                 input rmd_pkg::t_word multiplier,
                                 input rmd_pkg::t_word divisor);
        while (int'($urandom_range(99)) < idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.value      <= value;
        in_ch.multiplier <= multiplier;
        in_ch.divisor    <= divisor;
        @(posedge clk);
        while (!in_ch.ready) begin
            @(posedge clk);
        end
    endtask

    task automatic send_random;
        rmd_pkg::t_word a;
        rmd_pkg::t_word b;
        rmd_pkg::t_word d;
        int             dv;
        longint         wide;
        case ($urandom_range(9))
            0, 1: begin
                a = $urandom;
                b = $urandom;
                d = $urandom;
            end
            2: begin
                a = rand_between(-1000, 1000);
                b = rand_between(-1000, 1000);
                d = rand_nonzero(-1000, 1000);
            end
            3: begin
                // ties for even divisors: value = k*divisor +/- divisor/2
                dv   = rand_nonzero(-4096, 4096);
                wide = longint'(rand_between(-50000, 50000)) * dv;
                wide = $urandom_range(1) ? wide + dv / 2 : wide - dv / 2;
                a    = rmd_pkg::t_word'(wide);
                b    = $urandom_range(1) ? 32'sd1 : -32'sd1;
                d    = dv;
            end
            4: begin
                // near the range limits of the quotient
                dv = rand_nonzero(-32768, 32767);
                a  = $urandom_range(1) ? WORD_MAX - $urandom_range(1000)
                                       : WORD_MIN + $urandom_range(1000);
                b  = dv + rand_between(-2, 2);
                d  = dv;
            end
            5: begin
                a = $urandom;
                b = $urandom;
                d = '0;
            end
            6: begin
                a = $urandom;
                b = $urandom;
                case ($urandom_range(5))
                    0: d = 32'sd1;
                    1: d = -32'sd1;
                    2: d = WORD_MIN;
                    3: d = WORD_MAX;
                    4: d = 32'sd2;
                    default: d = -32'sd2;
                endcase
            end
            7: begin
                a = $urandom_range(1) ? 32'd0 : $urandom;
                b = (a == 0) ? $urandom : 32'd0;
                d = $urandom;
            end
            8: begin
                a = rand_between(-65536, 65535);
                b = rand_between(-65536, 65535);
                d = $urandom;
            end
            default: begin
                a = $urandom;
                b = rand_between(-16, 16);
                d = rand_nonzero(-256, 256);
            end
        endcase
        send_operands(a, b, d);
    endtask

    initial begin
        rst_n            <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.value      <= '0;
        in_ch.multiplier <= '0;
        in_ch.divisor    <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        send_operands(32'd0, 32'd0, 32'd0);
        send_operands(32'd7, 32'd3, 32'd0);
        send_operands(WORD_MAX, WORD_MAX, 32'sd1);
        send_operands(WORD_MIN, WORD_MIN, WORD_MIN);
        send_operands(WORD_MIN, 32'sd1, -32'sd1);
        send_operands(WORD_MIN, -32'sd1, 32'sd1);
        send_operands(WORD_MAX, 32'sd1, 32'sd1);
        send_operands(WORD_MIN, 32'sd1, 32'sd1);
        send_operands(WORD_MAX, WORD_MAX, WORD_MAX);
        send_operands(WORD_MIN, WORD_MAX, WORD_MAX);
        send_operands(32'd0, 32'sd12345, -32'sd5);
        send_operands(32'd0, 32'd0, WORD_MIN);
        send_operands(32'sd1, 32'sd1, -32'sd1);
        send_operands(32'sd5, 32'sd1, 32'sd2);
        send_operands(-32'sd5, 32'sd1, 32'sd2);
        send_operands(32'sd5, 32'sd1, -32'sd2);
        send_operands(-32'sd5, -32'sd1, -32'sd2);
        send_operands(32'sd3, 32'sd1, 32'sd2);
        send_operands(32'sd1, 32'sd1, 32'sd3);
        send_operands(-32'sd1, 32'sd1, 32'sd3);
        send_operands(32'sd7, 32'sd3, -32'sd7);
        send_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_operands(WORD_MAX, WORD_MIN, WORD_MIN);

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 86; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 86; end
                default: begin idle_pct = 8; stall_pct = 8; end
            endcase
            repeat (PHASE_ITEMS) send_random();
        end
        in_ch.valid <= 1'b0;

        do begin
            @(posedge clk);
        end while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

[rounded_multiply_divide.f]
hw/rtl/rmd_pkg.sv
hw/rtl/rmd_ifs.sv
hw/rtl/rmd_div.sv
hw/rtl/rounded_multiply_divide.sv
tb/rmd_checker.sv
tb/tb_top.sv
